>>> design/sust_pkg.sv
// shared types and constants for the sorted unique set table
`default_nettype none

package sust_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // operation codes carried by a request
    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_MODIFY = 3'd2,
        OP_LOOKUP = 3'd3,
        OP_DUMP   = 3'd4
    } op_t;

    // result status codes
    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_DUP      = 3'd1,
        STAT_NOTFOUND = 3'd2,
        STAT_EMPTY    = 3'd3,
        STAT_FULL     = 3'd4,
        STAT_FOUND    = 3'd5
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP,
        S_DUMP
    } state_t;

    // update command from the sequencer to the entry store
    typedef struct packed {
        logic ins;
        logic del;
    } sust_cmd_t;

endpackage

`default_nettype wire

>>> design/sust_cmp.sv
// shared signed comparator used by every scan step
`default_nettype none

module sust_cmp #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic [VALUE_WIDTH-1:0] a,
    input  wire logic [VALUE_WIDTH-1:0] b,
    output logic                        lt,
    output logic                        eq
);

    assign lt = $signed(a) < $signed(b);
    assign eq = a == b;

endmodule

`default_nettype wire

>>> design/sust_store.sv
// entry store: row of cells with parallel shift for insert and remove
`default_nettype none

module sust_store
    import sust_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int IW         = $clog2(CAPACITY)
) (
    input  wire logic                   aclk,
    input  wire sust_cmd_t              cmd,
    input  wire logic [IW-1:0]          pos,
    input  wire logic [VALUE_WIDTH-1:0] wdata,
    input  wire logic [IW-1:0]          rd_idx,
    output logic [VALUE_WIDTH-1:0]      rd_data
);

    logic [VALUE_WIDTH-1:0] entries_reg [CAPACITY];

    assign rd_data = entries_reg[rd_idx];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VALUE_WIDTH-1:0] prev_w;
        logic [VALUE_WIDTH-1:0] succ_w;

        if (i > 0) begin : g_prev
            assign prev_w = entries_reg[i-1];
        end else begin : g_first
            assign prev_w = wdata;
        end

        if (i < CAPACITY - 1) begin : g_succ
            assign succ_w = entries_reg[i+1];
        end else begin : g_end
            assign succ_w = entries_reg[i];
        end

        // insert opens a gap at pos, remove closes the gap at pos
        always_ff @(posedge aclk) begin
            if (cmd.ins) begin
                if (IW'(i) == pos) begin
                    entries_reg[i] <= wdata;
                end else if (IW'(i) > pos) begin
                    entries_reg[i] <= prev_w;
                end
            end else if (cmd.del) begin
                if (IW'(i) >= pos) begin
                    entries_reg[i] <= succ_w;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> design/sust_ctrl.sv
// sequencer: scans the store one entry a cycle and issues updates and results
`default_nettype none

module sust_ctrl
    import sust_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int IW         = $clog2(CAPACITY),
    localparam int CW         = $clog2(CAPACITY + 1)
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [2:0]             in_op,
    input  wire logic [VALUE_WIDTH-1:0] in_value,
    input  wire logic [VALUE_WIDTH-1:0] in_new_value,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output status_t                     out_status,
    output logic [VALUE_WIDTH-1:0]      out_entry,
    output logic                        out_last,
    input  wire logic                   cmp_lt,
    input  wire logic                   cmp_eq,
    output logic [VALUE_WIDTH-1:0]      key,
    input  wire logic [VALUE_WIDTH-1:0] rd_data,
    output logic [IW-1:0]               rd_idx,
    output sust_cmd_t                   cmd,
    output logic [IW-1:0]               cmd_pos
);

    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [VALUE_WIDTH-1:0] key_reg, key_next;
    logic [VALUE_WIDTH-1:0] nv_reg, nv_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [IW-1:0]          pos_reg, pos_next;
    logic [1:0]             phase_reg, phase_next;
    status_t                stat_reg, stat_next;
    logic                   m_valid_reg, m_valid_next;
    status_t                m_status_reg, m_status_next;
    logic [VALUE_WIDTH-1:0] m_entry_reg, m_entry_next;
    logic                   m_last_reg, m_last_next;

    logic at_end;
    logic hit;
    logic out_free;

    assign key        = key_reg;
    assign rd_idx     = idx_reg[IW-1:0];
    assign out_valid  = m_valid_reg;
    assign out_status = m_status_reg;
    assign out_entry  = m_entry_reg;
    assign out_last   = m_last_reg;
    assign at_end     = idx_reg == cnt_reg;
    assign hit        = !at_end && cmp_eq;
    assign out_free   = !m_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg       <= op_next;
        key_reg      <= key_next;
        nv_reg       <= nv_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        phase_reg    <= phase_next;
        stat_reg     <= stat_next;
        m_status_reg <= m_status_next;
        m_entry_reg  <= m_entry_next;
        m_last_reg   <= m_last_next;
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        nv_next       = nv_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        stat_next     = stat_reg;
        m_valid_next  = m_valid_reg && !out_ready;
        m_status_next = m_status_reg;
        m_entry_next  = m_entry_reg;
        m_last_next   = m_last_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd_pos       = idx_reg[IW-1:0];

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next    = op_t'(in_op);
                    key_next   = in_value;
                    nv_next    = in_new_value;
                    idx_next   = '0;
                    phase_next = 2'd0;
                    case (in_op)
                        OP_INSERT, OP_LOOKUP: begin
                            state_next = S_SCAN;
                        end
                        OP_DELETE, OP_MODIFY: begin
                            if (cnt_reg == '0) begin
                                stat_next  = STAT_EMPTY;
                                state_next = S_RESP;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_DUMP: begin
                            if (cnt_reg == '0) begin
                                stat_next  = STAT_EMPTY;
                                state_next = S_RESP;
                            end else begin
                                state_next = S_DUMP;
                            end
                        end
                        default: begin
                            // unused codes are dropped without a result
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (!at_end && cmp_lt) begin
                    idx_next = idx_reg + CW'(1);
                end else begin
                    state_next = S_RESP;
                    case (op_reg)
                        OP_INSERT: begin
                            if (hit) begin
                                stat_next = STAT_DUP;
                            end else if (cnt_reg == CAP) begin
                                stat_next = STAT_FULL;
                            end else begin
                                cmd.ins   = 1'b1;
                                cnt_next  = cnt_reg + CW'(1);
                                stat_next = STAT_OK;
                            end
                        end
                        OP_DELETE: begin
                            if (!hit) begin
                                stat_next = STAT_NOTFOUND;
                            end else begin
                                cmd.del   = 1'b1;
                                cnt_next  = cnt_reg - CW'(1);
                                stat_next = STAT_OK;
                            end
                        end
                        OP_LOOKUP: begin
                            stat_next = hit ? STAT_FOUND : STAT_NOTFOUND;
                        end
                        OP_MODIFY: begin
                            case (phase_reg)
                                2'd0: begin
                                    // old value located, now probe the new one
                                    if (!hit) begin
                                        stat_next = STAT_NOTFOUND;
                                    end else begin
                                        pos_next   = idx_reg[IW-1:0];
                                        key_next   = nv_reg;
                                        idx_next   = '0;
                                        phase_next = 2'd1;
                                        state_next = S_SCAN;
                                    end
                                end
                                2'd1: begin
                                    // remove old value, then rescan for the slot
                                    if (hit) begin
                                        stat_next = STAT_DUP;
                                    end else begin
                                        cmd.del    = 1'b1;
                                        cmd_pos    = pos_reg;
                                        cnt_next   = cnt_reg - CW'(1);
                                        idx_next   = '0;
                                        phase_next = 2'd2;
                                        state_next = S_SCAN;
                                    end
                                end
                                default: begin
                                    cmd.ins   = 1'b1;
                                    cnt_next  = cnt_reg + CW'(1);
                                    stat_next = STAT_OK;
                                end
                            endcase
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = stat_reg;
                    m_entry_next  = '0;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            S_DUMP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = STAT_OK;
                    m_entry_next  = rd_data;
                    m_last_next   = (idx_reg + CW'(1)) == cnt_reg;
                    idx_next      = idx_reg + CW'(1);
                    if ((idx_reg + CW'(1)) == cnt_reg) begin
                        state_next = S_IDLE;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CAP)
        else $error("entry count above capacity");

    a_ins_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins |=> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("insert did not bump count");

    a_del_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.del |=> cnt_reg == $past(cnt_reg) - CW'(1))
        else $error("remove did not drop count");

    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.ins && cmd.del))
        else $error("insert and remove in one cycle");

    a_dump_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DUMP |-> idx_reg < cnt_reg)
        else $error("dump index past stored entries");
`endif

endmodule

`default_nettype wire

>>> design/sorted_unique_set_table_top.sv
// insert, delete and lookup scan up from the lowest entry to the key, then respond
// modify scans up to three times (old value, new value, slot after removal)
// dump gives one result per cycle while m_tready is high, one per stored entry
// one request at a time: the next is taken only after the last one's result has entered
// the result register, which can wait on m_tready; scans use the single shared comparator
// reset: synchronous active-low aresetn empties the set; entry cells are not cleared
`default_nettype none

module sorted_unique_set_table_top
    import sust_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // op[2:0], value[34:3], new_value[66:35], zero pad
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // status[2:0], entry[34:3], zero pad
    output logic             m_tlast    // final result of the request
);

    localparam int IW = $clog2(CAPACITY);

    // unpacked request fields
    logic [2:0]             in_op;
    logic [31:0]            in_value;
    logic [31:0]            in_new_value;
    logic [VALUE_WIDTH-1:0] key_value;
    logic [VALUE_WIDTH-1:0] key_new_value;

    // sequencer to store and comparator
    logic [VALUE_WIDTH-1:0] key;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic [IW-1:0]          rd_idx;
    sust_cmd_t              cmd;
    logic [IW-1:0]          cmd_pos;
    logic                   cmp_lt;
    logic                   cmp_eq;

    // result fields
    status_t                out_status;
    logic [VALUE_WIDTH-1:0] out_entry;

    assign in_op        = s_tdata[2:0];
    assign in_value     = s_tdata[34:3];
    assign in_new_value = s_tdata[66:35];

    // values are held at the working width, sign-extended or cut down
    assign key_value     = VALUE_WIDTH'($signed(in_value));
    assign key_new_value = VALUE_WIDTH'($signed(in_new_value));

    // result word packing, entry brought back to 32 bits signed
    assign m_tdata = {5'd0, 32'($signed(out_entry)), out_status};

    // sequencer with count, scan index and result register
    sust_ctrl #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_op        (in_op),
        .in_value     (key_value),
        .in_new_value (key_new_value),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (out_status),
        .out_entry    (out_entry),
        .out_last     (m_tlast),
        .cmp_lt       (cmp_lt),
        .cmp_eq       (cmp_eq),
        .key          (key),
        .rd_data      (rd_data),
        .rd_idx       (rd_idx),
        .cmd          (cmd),
        .cmd_pos      (cmd_pos)
    );

    // single comparator shared by every scan step
    sust_cmp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cmp (
        .a  (rd_data),
        .b  (key),
        .lt (cmp_lt),
        .eq (cmp_eq)
    );

    // ordered entry cells, shifted in parallel on insert and remove
    sust_store #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .aclk    (aclk),
        .cmd     (cmd),
        .pos     (cmd_pos),
        .wdata   (key),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

>>> sim/sust_checker.sv
// request and result monitor with sorted set predictor for the set table
`default_nettype none

module sust_checker
    import sust_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [71:0] s_tdata,   // op[2:0], value[34:3], new_value[66:35], zero pad
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,   // status[2:0], entry[34:3], zero pad
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t     status;
        logic [31:0] entry;
        logic        last;
    } result_t;

    logic signed [31:0] set_vals [CAPACITY];
    int                 set_count;
    result_t            due_results [$];
    int                 mismatches = 0;

    // first slot whose value is not below v
    function automatic int lower_pos(logic signed [31:0] v);
        int i;
        i = 0;
        while (i < set_count && set_vals[i] < v)
            i++;
        return i;
    endfunction

    function automatic bit holds(logic signed [31:0] v);
        int p;
        p = lower_pos(v);
        return (p < set_count) && (set_vals[p] == v);
    endfunction

    function automatic void remove_value(logic signed [31:0] v);
        int i;
        for (i = lower_pos(v); i < set_count - 1; i++)
            set_vals[i] = set_vals[i + 1];
        set_count--;
    endfunction

    function automatic void insert_value(logic signed [31:0] v);
        int p;
        int i;
        p = lower_pos(v);
        for (i = set_count; i > p; i--)
            set_vals[i] = set_vals[i - 1];
        set_vals[p] = v;
        set_count++;
    endfunction

    function automatic void push_result(status_t st, logic [31:0] e, logic lst);
        result_t r;
        r.status = st;
        r.entry  = e;
        r.last   = lst;
        due_results.push_back(r);
    endfunction

    // update the set for one request and queue the results it causes
    function automatic void apply_set_op(logic [2:0] op, logic signed [31:0] v,
                                         logic signed [31:0] nv);
        int i;
        case (op)
            OP_INSERT: begin
                if (holds(v))
                    push_result(STAT_DUP, '0, 1'b1);
                else if (set_count >= CAPACITY)
                    push_result(STAT_FULL, '0, 1'b1);
                else begin
                    insert_value(v);
                    push_result(STAT_OK, '0, 1'b1);
                end
            end
            OP_DELETE: begin
                if (set_count == 0)
                    push_result(STAT_EMPTY, '0, 1'b1);
                else if (!holds(v))
                    push_result(STAT_NOTFOUND, '0, 1'b1);
                else begin
                    remove_value(v);
                    push_result(STAT_OK, '0, 1'b1);
                end
            end
            OP_MODIFY: begin
                if (set_count == 0)
                    push_result(STAT_EMPTY, '0, 1'b1);
                else if (!holds(v))
                    push_result(STAT_NOTFOUND, '0, 1'b1);
                else if (holds(nv))
                    push_result(STAT_DUP, '0, 1'b1);
                else begin
                    remove_value(v);
                    insert_value(nv);
                    push_result(STAT_OK, '0, 1'b1);
                end
            end
            OP_LOOKUP: begin
                push_result(holds(v) ? STAT_FOUND : STAT_NOTFOUND, '0, 1'b1);
            end
            OP_DUMP: begin
                if (set_count == 0)
                    push_result(STAT_EMPTY, '0, 1'b1);
                else
                    for (i = 0; i < set_count; i++)
                        push_result(STAT_OK, set_vals[i], i == set_count - 1);
            end
            default: ;   // unused codes are dropped
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin : monitor
        result_t want;
        if (!aresetn) begin
            set_count = 0;
            due_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                apply_set_op(s_tdata[2:0], s_tdata[34:3], s_tdata[66:35]);
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status %0d entry %0d last %0b",
                                              m_tdata[2:0], $signed(m_tdata[34:3]), m_tlast));
                end else begin
                    want = due_results.pop_front();
                    if (m_tdata[2:0] !== want.status || m_tdata[34:3] !== want.entry ||
                        m_tlast !== want.last)
                        report_mismatch($sformatf(
                            "status %0d/%0d entry %0d/%0d last %0b/%0b (got/want)",
                            m_tdata[2:0], want.status, $signed(m_tdata[34:3]),
                            $signed(want.entry), m_tlast, want.last));
                end
            end
        end
        pending    <= due_results.size();
        fail_count <= mismatches;
    end

endmodule

`default_nettype wire

>>> sim/testbench.sv
// stimulus and verdict for the sorted unique set table
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sust_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RANDOM_ITEMS  = 105;
    localparam int POOL_SIZE     = 24;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 200;   // quiet time after the drain, so that a stray extra result is caught

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;   // op[2:0], value[34:3], new_value[66:35], zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // status[2:0], entry[34:3], zero pad
    logic        m_tlast;

    int fail_count;
    int pending;

    // idle percentages of the two sides, changed between phases
    int send_idle = 20;
    int recv_idle = 73;

    // small pool of values so that hits, duplicates and a full set are common
    logic [31:0] value_pool [POOL_SIZE];

    sorted_unique_set_table_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    sust_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #CLK_HALF aclk = ~aclk;

    // receiver back-pressure, one decision per cycle at the falling edge
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // hard stop in case the block hangs
    initial begin
        #(20_000_000);
        $display("Regression FAIL");
        $finish;
    end

    // present one request and hold it until the block takes it
    task automatic send_request(logic [2:0] op, logic [31:0] value, logic [31:0] new_value);
        @(negedge aclk);
        // random gap before the request, valid stays low meanwhile
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {5'b0, new_value, value, op};
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    // mostly pool values, sometimes a fully random one
    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 99) < 85)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom();
    endfunction

    initial begin : stimulus
        int          sent;
        int          r;
        int          guard;
        bit          grow;
        logic [2:0]  op;
        logic [31:0] v;
        logic [31:0] nv;

        // extremes and neighbors of zero first, the rest random
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        value_pool[4] = 32'h0000_0001;
        for (int i = 5; i < POOL_SIZE; i++)
            value_pool[i] = $urandom();

        // reset held low from the start, released at a falling edge
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // operations on an empty set
        send_request(OP_LOOKUP, 32'd5, 32'd0);
        send_request(OP_DELETE, 32'd5, 32'd0);
        send_request(OP_MODIFY, 32'd5, 32'd6);
        send_request(OP_DUMP,   32'd0, 32'd0);

        // extremes of the value range and a duplicate
        send_request(OP_INSERT, 32'h8000_0000, 32'hffff_ffff);
        send_request(OP_INSERT, 32'h7fff_ffff, 32'h0000_0000);
        send_request(OP_INSERT, 32'd0, 32'd0);
        send_request(OP_INSERT, 32'hffff_ffff, 32'd0);
        send_request(OP_INSERT, 32'd0, 32'd0);

        // lookups that hit and miss
        send_request(OP_LOOKUP, 32'd0, 32'd0);
        send_request(OP_LOOKUP, 32'd1, 32'd0);
        send_request(OP_LOOKUP, 32'h7fff_ffff, 32'd0);

        // modify: new equals old, new already present, old absent, then a good one
        send_request(OP_MODIFY, 32'd0, 32'd0);
        send_request(OP_MODIFY, 32'hffff_ffff, 32'h7fff_ffff);
        send_request(OP_MODIFY, 32'd7, 32'd8);
        send_request(OP_MODIFY, 32'hffff_ffff, 32'd100);

        // delete hit and miss
        send_request(OP_DELETE, 32'd100, 32'd0);
        send_request(OP_DELETE, 32'd55, 32'd0);

        // unused op codes must be swallowed with no result
        send_request(3'd5, 32'hffff_ffff, 32'hffff_ffff);
        send_request(3'd6, 32'h1234_5678, 32'h8765_4321);
        send_request(3'd7, 32'd0, 32'd0);

        send_request(OP_DUMP, 32'd0, 32'd0);

        // random part: alternating grow and shrink stretches so the set
        // tends to fill up toward capacity and drain back toward empty
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent == RANDOM_ITEMS / 3) begin
                send_idle = 73;
                recv_idle = 20;
            end else if (sent == 2 * RANDOM_ITEMS / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end
            grow = ((sent / 24) % 2) == 0;
            v    = pick_value();
            nv   = ($urandom_range(0, 9) == 0) ? v : pick_value();
            r    = $urandom_range(0, 99);
            if (r < 3) begin
                // noise with an unused code, not counted
                send_request(3'($urandom_range(5, 7)), v, nv);
            end else begin
                r = $urandom_range(0, 99);
                if (grow)
                    op = (r < 55) ? OP_INSERT : (r < 65) ? OP_DELETE :
                         (r < 77) ? OP_MODIFY : (r < 92) ? OP_LOOKUP : OP_DUMP;
                else
                    op = (r < 10) ? OP_INSERT : (r < 58) ? OP_DELETE :
                         (r < 73) ? OP_MODIFY : (r < 92) ? OP_LOOKUP : OP_DUMP;
                send_request(op, v, nv);
                sent++;
            end
        end
        @(negedge aclk);
        s_tvalid = 1'b0;

        // drain every outstanding result, then give the block time to go quiet
        guard = 0;
        while (pending != 0 && guard < DRAIN_LIMIT) begin
            @(negedge aclk);
            guard++;
        end
        if (pending != 0) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            repeat (SETTLE_CYCLES) @(negedge aclk);
            if (fail_count == 0 && pending == 0) begin
                $display("Regression PASS");
            end else begin
                $display("Regression FAIL");
            end
            $finish;
        end
    end

endmodule

`default_nettype wire
